// File: src/seeded_cluster_grower_assert.svh
// Assertion macros used by the checker file of the cluster grower.
`ifndef SEEDED_CLUSTER_GROWER_ASSERT_SVH
`define SEEDED_CLUSTER_GROWER_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define SCG_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define SCG_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: src/scg_pkg.sv
// Types, codes and constants of the seeded cluster grower.
`timescale 1ns / 1ps
package scg_pkg;

	localparam int CHARGE_W = 16;
	localparam int KTHR_W   = 20;
	localparam int SUM_W    = 21;
	localparam int SIZE_W   = 13;
	localparam int POS_W    = 6;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		REG_KTHR = 2'd0,
		REG_ETHR = 2'd1,
		REG_COLS = 2'd2,
		REG_ROWS = 2'd3
	} reg_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CLR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SEED,
		ST_POP,
		ST_CELL,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_SUM_CHK,
		ST_GROW_RD,
		ST_GROW_CHK,
		ST_FIN
	} state_e;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [POS_W-1:0]           col;
		logic [POS_W-1:0]           row;
		logic signed [CHARGE_W-1:0] charge;
	} item_t;

	typedef struct packed {
		logic signed [CHARGE_W-1:0] cell_charge;
		logic                       in_cluster;
		logic [SIZE_W-1:0]          cluster_size;
		logic [POS_W-1:0]           seed_col;
		logic [POS_W-1:0]           seed_row;
	} result_t;

	typedef struct packed {
		logic signed [KTHR_W-1:0]   kthr;
		logic signed [CHARGE_W-1:0] ethr;
		logic [6:0]                 cols;
		logic [6:0]                 rows;
	} cfg_t;

	typedef struct packed {
		logic ch_we;
		logic mk_we;
		logic mk_wd;
	} store_ctl_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} fifo_ctl_t;

	// neighbor walk: column offset outer, row offset inner
	function automatic logic signed [1:0] nb_dc(input logic [3:0] k);
		logic signed [1:0] d;
		case (k)
			4'd0, 4'd1, 4'd2: d = -2'sd1;
			4'd3, 4'd4, 4'd5: d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] nb_dr(input logic [3:0] k);
		logic signed [1:0] d;
		case (k)
			4'd0, 4'd3, 4'd6: d = -2'sd1;
			4'd1, 4'd4, 4'd7: d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

endpackage

// File: src/scg_store.sv
// Charge store and cluster mark memories with registered read.
`timescale 1ns / 1ps
module scg_store #(
	parameter int AW = 12
) (
	input  logic                               clk,
	input  logic [AW-1:0]                      addr,
	input  scg_pkg::store_ctl_t                ctl,
	input  logic signed [scg_pkg::CHARGE_W-1:0] wdata,
	output logic signed [scg_pkg::CHARGE_W-1:0] charge,
	output logic                               mark
);
	import scg_pkg::*;

	logic signed [CHARGE_W-1:0] ch_mem [2**AW];
	logic                       mk_mem [2**AW];
	logic signed [CHARGE_W-1:0] charge_q;
	logic                       mark_q;

	always_ff @(posedge clk) begin
		if (ctl.ch_we) begin
			ch_mem[addr] <= wdata;
		end
		charge_q <= ch_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.mk_we) begin
			mk_mem[addr] <= ctl.mk_wd;
		end
		mark_q <= mk_mem[addr];
	end

	assign charge = charge_q;
	assign mark   = mark_q;
endmodule

// File: src/scg_fifo.sv
// Frontier queue of cell addresses for the breadth-first walk.
`timescale 1ns / 1ps
module scg_fifo #(
	parameter int AW = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scg_pkg::fifo_ctl_t ctl,
	input  logic [AW-1:0]      wdata,
	output logic [AW-1:0]      rdata,
	output logic               empty
);
	import scg_pkg::*;

	logic [AW-1:0] mem [2**AW];
	logic [AW:0]   head_q;
	logic [AW:0]   tail_q;
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= head_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q[AW-1:0]] <= wdata;
		end
		rdata_q <= mem[head_q[AW-1:0]];
	end

	assign rdata = rdata_q;
	assign empty = (head_q == tail_q);
endmodule

// File: src/scg_ctrl.sv
// Sequencer and shared add/subtract unit for commands, seed search and growth.
`timescale 1ns / 1ps
module scg_ctrl #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64,
	localparam int CW = $clog2(GRID_COLS),
	localparam int RW = $clog2(GRID_ROWS),
	localparam int AW = CW + RW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scg_pkg::cfg_t                       cfg,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  scg_pkg::item_t                      item,
	output scg_pkg::result_t                    res,
	output logic                                res_valid,
	input  logic                                res_take,
	output logic [AW-1:0]                       st_addr,
	output scg_pkg::store_ctl_t                 st_ctl,
	output logic signed [scg_pkg::CHARGE_W-1:0] st_wdata,
	input  logic signed [scg_pkg::CHARGE_W-1:0] st_charge,
	input  logic                                st_mark,
	output scg_pkg::fifo_ctl_t                  q_ctl,
	output logic [AW-1:0]                       q_wdata,
	input  logic [AW-1:0]                       q_rdata,
	input  logic                                q_empty
);
	import scg_pkg::*;

	state_e state_q, state_d;

	logic [AW-1:0]              cnt_q;
	logic [CW-1:0]              x_q, bc_q, c_q;
	logic [RW-1:0]              y_q, br_q, r_q;
	logic signed [CHARGE_W-1:0] best_q;
	logic                       first_q;
	logic [3:0]                 k_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic                       inb_q;
	logic [AW-1:0]              nb_addr_q;
	logic [SIZE_W-1:0]          size_q;
	logic                       ran_q;
	logic                       rd_ok_q;
	result_t                    res_q;

	logic [CW:0]             ncl;
	logic [RW:0]             nrl;
	logic                    item_ok;
	logic [AW-1:0]           item_addr;
	logic signed [CW+1:0]    xs;
	logic signed [RW+1:0]    ys;
	logic                    inb;
	logic [AW-1:0]           nb_addr;
	logic signed [SUM_W-1:0] alu_a, alu_b, alu_y, ch_ext;
	logic                    alu_sub;
	logic                    alu_neg, alu_pos;
	logic                    x_last, y_last, k_last;
	logic                    join_c;

	always_comb begin
		if (cfg.cols == 7'd0) begin
			ncl = (CW+1)'(1);
		end else if (32'(cfg.cols) > GRID_COLS) begin
			ncl = (CW+1)'(GRID_COLS);
		end else begin
			ncl = (CW+1)'(cfg.cols);
		end
		if (cfg.rows == 7'd0) begin
			nrl = (RW+1)'(1);
		end else if (32'(cfg.rows) > GRID_ROWS) begin
			nrl = (RW+1)'(GRID_ROWS);
		end else begin
			nrl = (RW+1)'(cfg.rows);
		end
	end

	assign item_ok   = (32'(item.col) < GRID_COLS) && (32'(item.row) < GRID_ROWS);
	assign item_addr = {RW'(item.row), CW'(item.col)};

	assign xs      = $signed({2'b00, c_q}) + (CW+2)'(nb_dc(k_q));
	assign ys      = $signed({2'b00, r_q}) + (RW+2)'(nb_dr(k_q));
	assign inb     = !xs[CW+1] && (xs < $signed({1'b0, ncl}))
		&& !ys[RW+1] && (ys < $signed({1'b0, nrl}));
	assign nb_addr = {ys[RW-1:0], xs[CW-1:0]};

	assign ch_ext  = SUM_W'(st_charge);
	assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign alu_neg = alu_y[SUM_W-1];
	assign alu_pos = !alu_neg && (alu_y != '0);

	assign x_last = ({1'b0, x_q} + 1'b1) == ncl;
	assign y_last = ({1'b0, y_q} + 1'b1) == nrl;
	assign k_last = (k_q == 4'd8);
	assign join_c = inb_q && !st_mark && alu_pos;

	assign st_wdata = item.charge;
	assign res      = res_q;

	always_comb begin
		state_d    = state_q;
		st_addr    = nb_addr_q;
		st_ctl     = '0;
		q_ctl      = '0;
		q_wdata    = nb_addr_q;
		alu_a      = acc_q;
		alu_b      = ch_ext;
		alu_sub    = 1'b0;
		item_stall = 1'b1;
		res_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				st_addr    = item_addr;
				if (item_valid) begin
					case (item.cmd)
						CMD_WRITE: begin
							st_ctl.ch_we = item_ok;
							state_d      = ST_FIN;
						end
						CMD_RUN:  state_d = ST_CLR;
						CMD_READ: state_d = ST_RD;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_RD: state_d = ST_FIN;
			ST_CLR: begin
				st_addr      = cnt_q[AW-1:0];
				st_ctl.mk_we = 1'b1;
				q_ctl.clear  = 1'b1;
				if (cnt_q[AW-1:0] == '1) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				st_addr = {y_q, x_q};
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				alu_a   = ch_ext;
				alu_b   = SUM_W'(best_q);
				alu_sub = 1'b1;
				state_d = (x_last && y_last) ? ST_SEED : ST_SCAN_RD;
			end
			ST_SEED: begin
				q_ctl.push = 1'b1;
				q_wdata    = {br_q, bc_q};
				state_d    = ST_POP;
			end
			ST_POP: begin
				if (q_empty) begin
					state_d = ST_FIN;
				end else begin
					q_ctl.pop = 1'b1;
					state_d   = ST_CELL;
				end
			end
			ST_CELL: state_d = ST_SUM_RD;
			ST_SUM_RD: begin
				st_addr = nb_addr;
				state_d = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				alu_a   = acc_q;
				alu_b   = inb_q ? ch_ext : '0;
				state_d = k_last ? ST_SUM_CHK : ST_SUM_RD;
			end
			ST_SUM_CHK: begin
				alu_a   = acc_q;
				alu_b   = SUM_W'(cfg.kthr);
				alu_sub = 1'b1;
				state_d = alu_neg ? ST_POP : ST_GROW_RD;
			end
			ST_GROW_RD: begin
				st_addr = nb_addr;
				state_d = ST_GROW_CHK;
			end
			ST_GROW_CHK: begin
				alu_a   = ch_ext;
				alu_b   = SUM_W'(cfg.ethr);
				alu_sub = 1'b1;
				if (join_c) begin
					st_ctl.mk_we = 1'b1;
					st_ctl.mk_wd = 1'b1;
					q_ctl.push   = 1'b1;
				end
				state_d = k_last ? ST_POP : ST_GROW_RD;
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ran_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_POP && q_empty) begin
				ran_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_ok_q <= item_ok;
				cnt_q   <= '0;
				res_q   <= '0;
			end
			ST_RD: begin
				if (rd_ok_q && ran_q && st_mark) begin
					res_q.cell_charge <= st_charge;
					res_q.in_cluster  <= 1'b1;
				end
			end
			ST_CLR: begin
				cnt_q   <= cnt_q + 1'b1;
				x_q     <= '0;
				y_q     <= '0;
				first_q <= 1'b1;
				size_q  <= '0;
			end
			ST_SCAN_CMP: begin
				if (first_q || alu_pos) begin
					best_q <= st_charge;
					bc_q   <= x_q;
					br_q   <= y_q;
				end
				first_q <= 1'b0;
				if (x_last) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			ST_POP: begin
				res_q.cluster_size <= size_q;
				res_q.seed_col     <= POS_W'(bc_q);
				res_q.seed_row     <= POS_W'(br_q);
			end
			ST_CELL: begin
				c_q   <= q_rdata[CW-1:0];
				r_q   <= q_rdata[AW-1:CW];
				k_q   <= '0;
				acc_q <= '0;
			end
			ST_SUM_RD, ST_GROW_RD: begin
				nb_addr_q <= nb_addr;
				inb_q     <= inb;
			end
			ST_SUM_ACC: begin
				acc_q <= alu_y;
				k_q   <= k_last ? 4'd0 : k_q + 1'b1;
			end
			ST_GROW_CHK: begin
				if (join_c) begin
					size_q <= size_q + 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end
endmodule

// File: src/seeded_cluster_grower.sv
// Top level of the seeded 3x3 cluster grower.
//
// Item channel (item_valid/item_stall/item) carries commands: cmd 0 writes one
// cell charge, cmd 1 runs clustering, cmd 2 reads one cell. Every item gives
// exactly one result on the result channel (result_valid/result_stall/result).
// Configuration registers are written on cfg_valid/cfg_ready, which is always
// ready; write them only while no item is in flight.
// A run clears the whole mark memory (all 2^AW addresses), scans each cell of
// the grid in use to find the seed, then per dequeued frontier cell sums the
// neighborhood and, when it reaches the threshold, spreads; the single-port
// memories and the one shared add/subtract unit serialize these steps.
// One item is worked at a time; item_stall is high until its result is
// placed in the output register. The output register holds a result while
// result_stall is high, and the next item is accepted meanwhile.
// Reset clears the configuration to its defaults and empties the cluster;
// the charge grid is undefined until written.
`timescale 1ns / 1ps
module seeded_cluster_grower #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  scg_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output scg_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [19:0]      cfg_data
);
	import scg_pkg::*;

	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int AW = CW + RW;

	cfg_t       cfg_q;
	logic       result_valid_q;
	result_t    result_q;
	logic       out_free;
	result_t    res;
	logic       res_valid;
	logic [AW-1:0]              st_addr;
	store_ctl_t                 st_ctl;
	logic signed [CHARGE_W-1:0] st_wdata;
	logic signed [CHARGE_W-1:0] st_charge;
	logic                       st_mark;
	fifo_ctl_t                  q_ctl;
	logic [AW-1:0]              q_wdata;
	logic [AW-1:0]              q_rdata;
	logic                       q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kthr <= '0;
			cfg_q.ethr <= '0;
			cfg_q.cols <= 7'd64;
			cfg_q.rows <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KTHR: cfg_q.kthr <= cfg_data;
				REG_ETHR: cfg_q.ethr <= cfg_data[CHARGE_W-1:0];
				REG_COLS: cfg_q.cols <= cfg_data[6:0];
				REG_ROWS: cfg_q.rows <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	scg_ctrl #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (out_free),
		.st_addr   (st_addr),
		.st_ctl    (st_ctl),
		.st_wdata  (st_wdata),
		.st_charge (st_charge),
		.st_mark   (st_mark),
		.q_ctl     (q_ctl),
		.q_wdata   (q_wdata),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty)
	);

	scg_store #(
		.AW(AW)
	) u_store (
		.clk   (clk),
		.addr  (st_addr),
		.ctl   (st_ctl),
		.wdata (st_wdata),
		.charge(st_charge),
		.mark  (st_mark)
	);

	scg_fifo #(
		.AW(AW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (q_ctl),
		.wdata (q_wdata),
		.rdata (q_rdata),
		.empty (q_empty)
	);
endmodule

// File: src/scg_checker.sv
// Port-level checks of the cluster grower and their binding to the top level.
`timescale 1ns / 1ps
`include "seeded_cluster_grower_assert.svh"
module scg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input scg_pkg::result_t result
);
	import scg_pkg::*;

	`SCG_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
	`SCG_ASSERT_NEXT(a_out_stable, result_valid && result_stall, $stable(result), "stalled result changed")
	`SCG_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accepted a second transaction before finishing")
	`SCG_ASSERT_NOW(a_result_from_busy, $rose(result_valid), $past(item_stall), "result appeared without a transaction in flight")
endmodule

bind seeded_cluster_grower scg_checker u_scg_checker (.*);

// File: tb/sv/tb_seeded_cluster_grower.sv
// Self-checking testbench of the seeded 3x3 cluster grower.
`timescale 1ns / 1ps
module tb_seeded_cluster_grower;
	import scg_pkg::*;

	localparam int NCOL = 64;
	localparam int NROW = 64;
	localparam int LIMIT = 4000000;

	typedef struct {
		item_t   it;
		bit      fixed;
		result_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	logic signed [CHARGE_W-1:0] grid_charge [NCOL*NROW];
	bit cell_marked [NCOL*NROW];
	bit cell_loaded [NCOL*NROW];
	int kthr_val, ethr_val;
	logic [6:0] cols_reg, rows_reg;

	result_t pending_results [$];
	dir_row_t dir_tab [$];
	int errors = 0;
	int cycles = 0;
	int items_done = 0;
	int snd_idle = 0, rcv_idle = 0;

	seeded_cluster_grower dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void add_row(dir_row_t r);
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	function automatic int used_dim(logic [6:0] v, int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic int neighborhood_sum(int c, int r, int nc, int nr);
		int s;
		s = 0;
		for (int dc = -1; dc <= 1; dc++)
			for (int dr = -1; dr <= 1; dr++)
				if (c + dc >= 0 && c + dc < nc && r + dr >= 0 && r + dr < nr)
					s += int'(grid_charge[(r + dr) * NCOL + c + dc]);
		return s;
	endfunction

	function automatic result_t grow_cluster();
		result_t res;
		int nc, nr, bc, br, best, idx, c, r, n, sz;
		int frontier [$];
		res = '0;
		nc = used_dim(cols_reg, NCOL);
		nr = used_dim(rows_reg, NROW);
		bc = 0;
		br = 0;
		sz = 0;
		best = int'(grid_charge[0]);
		foreach (cell_marked[i]) cell_marked[i] = 1'b0;
		for (int y = 0; y < nr; y++)
			for (int x = 0; x < nc; x++)
				if (int'(grid_charge[y * NCOL + x]) > best) begin
					best = int'(grid_charge[y * NCOL + x]);
					bc = x;
					br = y;
				end
		frontier.insert(frontier.size(), br * NCOL + bc);
		while (frontier.size() != 0) begin
			idx = frontier.pop_front();
			c = idx % NCOL;
			r = idx / NCOL;
			if (neighborhood_sum(c, r, nc, nr) < kthr_val) continue;
			for (int dc = -1; dc <= 1; dc++)
				for (int dr = -1; dr <= 1; dr++) begin
					if (c + dc < 0 || c + dc >= nc || r + dr < 0 || r + dr >= nr) continue;
					n = (r + dr) * NCOL + c + dc;
					if (!cell_marked[n] && int'(grid_charge[n]) > ethr_val) begin
						cell_marked[n] = 1'b1;
						sz++;
						frontier.insert(frontier.size(), n);
					end
				end
		end
		res.cluster_size = sz[SIZE_W-1:0];
		res.seed_col = bc[POS_W-1:0];
		res.seed_row = br[POS_W-1:0];
		return res;
	endfunction

	function automatic result_t predict_result(item_t it);
		result_t res;
		int n;
		res = '0;
		n = int'(it.row) * NCOL + int'(it.col);
		case (it.cmd)
			CMD_WRITE: begin
				grid_charge[n] = it.charge;
				cell_loaded[n] = 1'b1;
			end
			CMD_RUN: res = grow_cluster();
			CMD_READ: if (cell_marked[n]) begin
				res.cell_charge = grid_charge[n];
				res.in_cluster = 1'b1;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_item(item_t it, bit fixed = 1'b0, result_t fres = '0);
		result_t pres;
		while ($urandom_range(99) < snd_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		pres = predict_result(it);
		pending_results.insert(pending_results.size(), fixed ? fres : pres);
		items_done++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_e idx, logic [19:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KTHR: kthr_val = int'($signed(val));
			REG_ETHR: ethr_val = int'($signed(val[15:0]));
			REG_COLS: cols_reg = val[6:0];
			default:  rows_reg = val[6:0];
		endcase
	endtask

	function automatic item_t make_item(cmd_e cmd, int c, int r, int q);
		item_t it;
		it.cmd = cmd;
		it.col = c[POS_W-1:0];
		it.row = r[POS_W-1:0];
		it.charge = q[CHARGE_W-1:0];
		return it;
	endfunction

	function automatic int rand_charge();
		if ($urandom_range(9) < 3) return int'($signed(16'($urandom())));
		return int'($urandom_range(1200)) - 200;
	endfunction

	task automatic fill_grid();
		int nc, nr;
		nc = used_dim(cols_reg, NCOL);
		nr = used_dim(rows_reg, NROW);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!cell_loaded[r * NCOL + c])
					send_item(make_item(CMD_WRITE, c, r, rand_charge()));
	endtask

	task automatic random_setup();
		int k;
		k = $urandom_range(9);
		if (k == 0) write_reg(REG_KTHR, 20'h80000);
		else if (k == 1) write_reg(REG_KTHR, 20'h7ffff);
		else write_reg(REG_KTHR, 20'(int'($urandom_range(6000)) - 1500));
		k = $urandom_range(9);
		if (k == 0) write_reg(REG_ETHR, 20'h08000);
		else if (k == 1) write_reg(REG_ETHR, 20'h07fff);
		else write_reg(REG_ETHR, 20'(int'($urandom_range(700)) - 300));
		k = $urandom_range(11);
		case (k)
			0: begin write_reg(REG_COLS, 20'd64); write_reg(REG_ROWS, 20'($urandom_range(2))); end
			1: begin write_reg(REG_COLS, 20'($urandom_range(2))); write_reg(REG_ROWS, 20'd127); end
			2: begin write_reg(REG_COLS, 20'd0); write_reg(REG_ROWS, 20'd0); end
			default: begin
				write_reg(REG_COLS, 20'($urandom_range(1, 9)));
				write_reg(REG_ROWS, 20'($urandom_range(1, 9)));
			end
		endcase
	endtask

	task automatic random_round();
		int nc, nr;
		nc = used_dim(cols_reg, NCOL);
		nr = used_dim(rows_reg, NROW);
		repeat ($urandom_range(12)) begin
			if ($urandom_range(9) == 0)
				send_item(make_item(CMD_NONE, $urandom_range(63), $urandom_range(63),
					rand_charge()));
			else if ($urandom_range(9) == 0)
				send_item(make_item(CMD_WRITE, $urandom_range(63), $urandom_range(63),
					rand_charge()));
			else
				send_item(make_item(CMD_WRITE, $urandom_range(nc - 1),
					$urandom_range(nr - 1), rand_charge()));
		end
		fill_grid();
		send_item(make_item(CMD_RUN, $urandom_range(63), $urandom_range(63), rand_charge()));
		repeat ($urandom_range(2, 12)) begin
			if ($urandom_range(4) == 0)
				send_item(make_item(CMD_READ, $urandom_range(63), $urandom_range(63),
					rand_charge()));
			else
				send_item(make_item(CMD_READ, $urandom_range(nc - 1),
					$urandom_range(nr - 1), rand_charge()));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) result_stall <= ($urandom_range(99) < rcv_idle);
	end

	always @(posedge clk) begin
		result_t exp_r;
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t timeout", $realtime);
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $realtime, result);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.cell_charge !== exp_r.cell_charge) begin
					$display("%0t cell_charge exp %0d act %0d", $realtime,
						exp_r.cell_charge, result.cell_charge);
					errors++;
				end
				if (result.in_cluster !== exp_r.in_cluster) begin
					$display("%0t in_cluster exp %0d act %0d", $realtime,
						exp_r.in_cluster, result.in_cluster);
					errors++;
				end
				if (result.cluster_size !== exp_r.cluster_size) begin
					$display("%0t cluster_size exp %0d act %0d", $realtime,
						exp_r.cluster_size, result.cluster_size);
					errors++;
				end
				if (result.seed_col !== exp_r.seed_col) begin
					$display("%0t seed_col exp %0d act %0d", $realtime,
						exp_r.seed_col, result.seed_col);
					errors++;
				end
				if (result.seed_row !== exp_r.seed_row) begin
					$display("%0t seed_row exp %0d act %0d", $realtime,
						exp_r.seed_row, result.seed_row);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t row_e;
		int target;
		kthr_val = 0;
		ethr_val = 0;
		cols_reg = 7'd64;
		rows_reg = 7'd64;
		foreach (cell_loaded[i]) begin
			cell_loaded[i] = 1'b0;
			cell_marked[i] = 1'b0;
			grid_charge[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read straight after reset and an unused command: both all zero
		row_e.res = '0;
		row_e.fixed = 1'b1;
		row_e.it = make_item(CMD_READ, 5, 5, 0);          add_row(row_e);
		row_e.it = make_item(CMD_NONE, 63, 63, -1);       add_row(row_e);
		foreach (dir_tab[i]) send_item(dir_tab[i].it, 1'b1, dir_tab[i].res);
		dir_tab.delete();

		write_reg(REG_COLS, 20'd3);
		write_reg(REG_ROWS, 20'd3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				row_e.fixed = 1'b1;
				row_e.it = make_item(CMD_WRITE, c, r,
					(c == 0 && r == 0) ? -32768 : (c == 2 && r == 2) ? 32767 :
					(c + r == 1) ? 500 : 100 * c - 50 * r);
				add_row(row_e);
			end
		row_e.fixed = 1'b0;
		row_e.it = make_item(CMD_RUN, 0, 0, 0);           add_row(row_e);
		row_e.it = make_item(CMD_READ, 2, 2, 0);          add_row(row_e);
		row_e.it = make_item(CMD_READ, 0, 0, 0);          add_row(row_e);
		// tie between (col 1, row 0) and (col 0, row 1): first in row-major wins
		row_e.fixed = 1'b1;
		row_e.it = make_item(CMD_WRITE, 2, 2, 400);       add_row(row_e);
		row_e.fixed = 1'b0;
		row_e.it = make_item(CMD_RUN, 63, 63, 32767);     add_row(row_e);
		row_e.it = make_item(CMD_READ, 1, 0, 0);          add_row(row_e);
		row_e.it = make_item(CMD_READ, 2, 1, 0);          add_row(row_e);
		row_e.fixed = 1'b1;
		row_e.it = make_item(CMD_READ, 63, 63, 0);        add_row(row_e);
		row_e.it = make_item(CMD_WRITE, 63, 63, 0);       add_row(row_e);
		row_e.it = make_item(CMD_NONE, 0, 0, 0);          add_row(row_e);
		foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].res);

		for (int m = 0; m < 3; m++) begin
			snd_idle = (m == 0) ? 27 : (m == 1) ? 86 : 0;
			rcv_idle = (m == 0) ? 86 : (m == 1) ? 27 : 0;
			target = items_done + 217;
			while (items_done < target) begin
				random_setup();
				fill_grid();
				repeat ($urandom_range(1, 3)) random_round();
			end
		end

		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/scg_pkg.sv
src/scg_store.sv
src/scg_fifo.sv
src/scg_ctrl.sv
src/seeded_cluster_grower.sv
src/scg_checker.sv
tb/sv/tb_seeded_cluster_grower.sv
